>>> src/tournament_tree_event_queue_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TOURNAMENT_TREE_EVENT_QUEUE_TOP_DEFINES_SVH
`define TOURNAMENT_TREE_EVENT_QUEUE_TOP_DEFINES_SVH
// Same-cycle implication, sampled on the rising clock edge.
`define TTEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge.
`define TTEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/tteq_pkg.sv
// ----------------------------------------------------------------------------
// Tournament tree event queue package
// Shared widths, operation codes and transaction structs.
// ----------------------------------------------------------------------------
package tteq_pkg;

  localparam int ID_W            = 11;
  localparam int TIME_W          = 48;
  localparam int CNT_OUT_W       = 11;
  localparam int MAX_ENTRIES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [ID_W-1:0]    entry_id;
    logic [TIME_W-1:0]  event_time;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]      winner_id;
    logic [TIME_W-1:0]    winner_time;
    logic [CNT_OUT_W-1:0] entries;
    logic                 error;
  } res_t;

endpackage

>>> src/tournament_tree_event_queue_top.sv
// ----------------------------------------------------------------------------
// Tournament tree event queue
// Priority queue of timed entries that reports the earliest entry.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. It carries
// an operation (insert, delete or update time), an entry id and a time.
// Every transaction gives exactly one result on res_o, marked by a one-cycle
// valid_o strobe: the winner id and time, the entry count and an error flag.
// The receiver cannot stall; the result is marked valid for one cycle only.
// The tree lives in three single-write memories with registered reads.
// Most transactions that change the tree walk it from a leaf towards the root,
// and at each level read the children, read their times and write the match.
// A delete may need two such walks.
// A new transaction is taken in the cycle in which valid_o is shown.
// After reset the winner memory is cleared, one node a cycle, and busy_o
// stays high until every node has been cleared.
// ----------------------------------------------------------------------------
module tournament_tree_event_queue_top #(
  parameter int MAX_ENTRIES = tteq_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tteq_pkg::req_t in_i,
  output logic          valid_o,
  output tteq_pkg::res_t res_o
);
  import tteq_pkg::*;

  localparam int NODES     = 2 * MAX_ENTRIES;
  localparam int NODE_W    = $clog2(NODES);
  localparam int IDX_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_INS0 = 16'h0004,
    S_INS1 = 16'h0008,
    S_INS2 = 16'h0010,
    S_DEL0 = 16'h0020,
    S_DEL1 = 16'h0040,
    S_DEL2 = 16'h0080,
    S_UPD0 = 16'h0100,
    S_UPD1 = 16'h0200,
    S_CH   = 16'h0400,
    S_TM   = 16'h0800,
    S_EV   = 16'h1000,
    S_FIN0 = 16'h2000,
    S_FIN1 = 16'h4000,
    S_FIN2 = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [ID_W-1:0]   wn_mem [NODES];
  logic [NODE_W-1:0] leaf_mem [MAX_ENTRIES+1];
  logic [TIME_W-1:0] et_mem [MAX_ENTRIES+1];

  logic              wn_we, leaf_we, et_we;
  logic [NODE_W-1:0] wn_wa, wn_ra_a, wn_ra_b;
  logic [ID_W-1:0]   wn_wd, wn_rd_a_q, wn_rd_b_q;
  logic [IDX_W-1:0]  leaf_wa, leaf_ra, et_wa, et_ra_a, et_ra_b;
  logic [NODE_W-1:0] leaf_wd, leaf_rd_q;
  logic [TIME_W-1:0] et_wd, et_rd_a_q, et_rd_b_q;

  op_e               op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d, cid_q, cid_d, hi_q, hi_d, l_q, l_d, r_q, r_d, w_q, w_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NODE_W-1:0] f_q, f_d, pid_q, pid_d, clr_q, clr_d;
  logic              phase_a_q, phase_a_d, second_q, second_d, err_q, err_d;
  logic              valid_q, valid_d;
  res_t              res_q, res_d;

  logic [NODE_W-1:0] c_node, c2_node;
  logic [ID_W-1:0]   lo_id, hi_id, x_id, win_id;
  logic              id_ok;

  always_ff @(posedge clk_i) begin
    if (wn_we) begin
      wn_mem[wn_wa] <= wn_wd;
    end
    wn_rd_a_q <= wn_mem[wn_ra_a];
    wn_rd_b_q <= wn_mem[wn_ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_rd_q <= leaf_mem[leaf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (et_we) begin
      et_mem[et_wa] <= et_wd;
    end
    et_rd_a_q <= et_mem[et_ra_a];
    et_rd_b_q <= et_mem[et_ra_b];
  end

  assign c_node  = NODE_W'(cnt_q);
  assign c2_node = NODE_W'(cnt_q) << 1;
  assign lo_id   = wn_rd_a_q;
  assign hi_id   = wn_rd_b_q;
  assign x_id    = (lo_id != id_q) ? lo_id : hi_id;
  assign win_id  = (et_rd_a_q < et_rd_b_q) ? l_q : r_q;
  assign id_ok   = (in_i.entry_id != '0) && (32'(in_i.entry_id) <= 32'(MAX_ENTRIES));

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    time_d    = time_q;
    cnt_d     = cnt_q;
    cid_d     = cid_q;
    hi_d      = hi_q;
    l_d       = l_q;
    r_d       = r_q;
    w_d       = w_q;
    f_d       = f_q;
    pid_d     = pid_q;
    clr_d     = clr_q;
    phase_a_d = phase_a_q;
    second_d  = second_q;
    err_d     = err_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    wn_we     = 1'b0;
    wn_wa     = '0;
    wn_wd     = '0;
    wn_ra_a   = '0;
    wn_ra_b   = '0;
    leaf_we   = 1'b0;
    leaf_wa   = '0;
    leaf_wd   = '0;
    leaf_ra   = '0;
    et_we     = 1'b0;
    et_wa     = '0;
    et_wd     = '0;
    et_ra_a   = '0;
    et_ra_b   = '0;
    case (state_q)
      S_CLR: begin
        wn_we = 1'b1;
        wn_wa = clr_q;
        if (clr_q == NODE_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + NODE_W'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          op_d   = in_i.operation;
          id_d   = in_i.entry_id;
          time_d = in_i.event_time;
          err_d  = 1'b0;
          if (!id_ok) begin
            state_d = S_FIN0;
          end else begin
            case (in_i.operation)
              OP_INSERT: begin
                if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
                  err_d   = 1'b1;
                  state_d = S_FIN0;
                end else begin
                  state_d = S_INS0;
                end
              end
              OP_DELETE: begin
                if (cnt_q == '0) begin
                  err_d   = 1'b1;
                  state_d = S_FIN0;
                end else begin
                  state_d = S_DEL0;
                end
              end
              OP_UPDATE: state_d = S_UPD0;
              default:   state_d = S_FIN0;
            endcase
          end
        end
      end
      S_INS0: begin
        et_we = 1'b1;
        et_wa = IDX_W'(id_q);
        et_wd = time_q;
        if (cnt_q == '0) begin
          wn_we   = 1'b1;
          wn_wa   = NODE_W'(1);
          wn_wd   = id_q;
          leaf_we = 1'b1;
          leaf_wa = IDX_W'(id_q);
          leaf_wd = NODE_W'(1);
          cnt_d   = CNT_W'(1);
          state_d = S_FIN0;
        end else begin
          wn_ra_a = c_node;
          state_d = S_INS1;
        end
      end
      S_INS1: begin
        cid_d   = wn_rd_a_q;
        wn_we   = 1'b1;
        wn_wa   = c2_node;
        wn_wd   = wn_rd_a_q;
        leaf_we = 1'b1;
        leaf_wa = IDX_W'(wn_rd_a_q);
        leaf_wd = c2_node;
        state_d = S_INS2;
      end
      S_INS2: begin
        wn_we     = 1'b1;
        wn_wa     = c2_node | NODE_W'(1);
        wn_wd     = id_q;
        leaf_we   = 1'b1;
        leaf_wa   = IDX_W'(id_q);
        leaf_wd   = c2_node | NODE_W'(1);
        cnt_d     = cnt_q + CNT_W'(1);
        f_d       = c_node;
        phase_a_d = 1'b1;
        second_d  = 1'b0;
        state_d   = S_CH;
      end
      S_DEL0: begin
        if (cnt_q == CNT_W'(1)) begin
          wn_we   = 1'b1;
          wn_wa   = NODE_W'(1);
          cnt_d   = '0;
          state_d = S_FIN0;
        end else begin
          wn_ra_a = c2_node - NODE_W'(2);
          wn_ra_b = c2_node - NODE_W'(1);
          leaf_ra = IDX_W'(id_q);
          state_d = S_DEL1;
        end
      end
      S_DEL1: begin
        hi_d      = hi_id;
        pid_d     = leaf_rd_q;
        second_d  = (lo_id != id_q) && (hi_id != id_q);
        leaf_we   = 1'b1;
        leaf_wa   = IDX_W'(x_id);
        leaf_wd   = c_node - NODE_W'(1);
        wn_we     = 1'b1;
        wn_wa     = c_node - NODE_W'(1);
        wn_wd     = x_id;
        cid_d     = x_id;
        f_d       = (c_node - NODE_W'(1)) >> 1;
        phase_a_d = 1'b1;
        cnt_d     = cnt_q - CNT_W'(1);
        state_d   = S_CH;
      end
      S_DEL2: begin
        wn_we     = 1'b1;
        wn_wa     = pid_q;
        wn_wd     = hi_q;
        leaf_we   = 1'b1;
        leaf_wa   = IDX_W'(hi_q);
        leaf_wd   = pid_q;
        cid_d     = hi_q;
        f_d       = pid_q >> 1;
        phase_a_d = 1'b1;
        second_d  = 1'b0;
        state_d   = S_CH;
      end
      S_UPD0: begin
        et_we   = 1'b1;
        et_wa   = IDX_W'(id_q);
        et_wd   = time_q;
        leaf_ra = IDX_W'(id_q);
        state_d = S_UPD1;
      end
      S_UPD1: begin
        cid_d     = id_q;
        f_d       = (32'(leaf_rd_q) >= 32'(NODES)) ? '0 : (leaf_rd_q >> 1);
        phase_a_d = 1'b1;
        second_d  = 1'b0;
        state_d   = S_CH;
      end
      S_CH: begin
        if (f_q == '0) begin
          state_d = second_q ? S_DEL2 : S_FIN0;
        end else begin
          wn_ra_a = f_q << 1;
          wn_ra_b = (f_q << 1) | NODE_W'(1);
          state_d = S_TM;
        end
      end
      S_TM: begin
        l_d     = wn_rd_a_q;
        r_d     = wn_rd_b_q;
        et_ra_a = IDX_W'(wn_rd_a_q);
        et_ra_b = IDX_W'(wn_rd_b_q);
        wn_ra_a = f_q;
        state_d = S_EV;
      end
      S_EV: begin
        wn_we = 1'b1;
        wn_wa = f_q;
        wn_wd = win_id;
        if (phase_a_q && (wn_rd_a_q == cid_q)) begin
          f_d     = f_q >> 1;
          state_d = S_CH;
        end else begin
          phase_a_d = 1'b0;
          if (win_id == wn_rd_a_q) begin
            state_d = second_q ? S_DEL2 : S_FIN0;
          end else begin
            f_d     = f_q >> 1;
            state_d = S_CH;
          end
        end
      end
      S_FIN0: begin
        wn_ra_a = NODE_W'(1);
        state_d = S_FIN1;
      end
      S_FIN1: begin
        w_d     = wn_rd_a_q;
        et_ra_a = IDX_W'(wn_rd_a_q);
        state_d = S_FIN2;
      end
      S_FIN2: begin
        res_d.winner_id   = (cnt_q != '0) ? w_q : '0;
        res_d.winner_time = (cnt_q != '0) ? et_rd_a_q : '0;
        res_d.entries     = CNT_OUT_W'(cnt_q);
        res_d.error       = err_q;
        valid_d           = 1'b1;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    time_q    <= time_d;
    cid_q     <= cid_d;
    hi_q      <= hi_d;
    l_q       <= l_d;
    r_q       <= r_d;
    w_q       <= w_d;
    f_q       <= f_d;
    pid_q     <= pid_d;
    phase_a_q <= phase_a_d;
    second_q  <= second_d;
    err_q     <= err_d;
    res_q     <= res_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/tteq_checker.sv
// ----------------------------------------------------------------------------
// Tournament tree event queue checker
// Port-level checks on transaction and result timing and on the empty-queue result.
// ----------------------------------------------------------------------------
`include "tournament_tree_event_queue_top_defines.svh"

module tteq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           valid_o,
  input tteq_pkg::res_t res_o
);
  import tteq_pkg::*;

  `TTEQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted transaction did not raise busy")
  `TTEQ_ASSERT_NEXT(a_single_strobe, valid_o, !valid_o, "result strobe lasted more than one cycle")
  `TTEQ_ASSERT_NOW(a_result_idle, valid_o, !busy_o, "result shown while still busy")
  `TTEQ_ASSERT_NOW(a_empty_zero, valid_o && (res_o.entries == '0), (res_o.winner_id == '0) && (res_o.winner_time == '0), "empty queue reported a winner")

endmodule

bind tournament_tree_event_queue_top tteq_checker u_tteq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .res_o   (res_o)
);

>>> tb/sv/tb_tournament_tree_event_queue_top.sv
// ----------------------------------------------------------------------------
// Tournament tree event queue testbench
// Drives insert, delete and update transactions into the queue and checks
// every result against a behavioral model of the tree kept in the bench.
// ----------------------------------------------------------------------------
module tb_tournament_tree_event_queue_top;
  import tteq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX      = 1024;
  localparam int NODES     = 2 * NMAX;
  localparam int WD_LIMIT  = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t in_i = '0;
  logic valid_o;
  res_t res_o;

  tournament_tree_event_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .in_i(in_i), .valid_o(valid_o), .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the tree.
  logic [ID_W-1:0]   win_node [NODES];
  logic [ID_W-1:0]   leaf_pos [NMAX+1];
  logic [TIME_W-1:0] ent_time [NMAX+1];
  int                ent_count;

  // Bookkeeping for stimulus: which ids are held, which were ever written.
  bit   held [NMAX+1];
  bit   written [NMAX+1];
  int   held_ids [$];

  res_t result_fifo [$];
  int   errors;
  int   idle_cnt;
  bit   idle_en;

  function automatic logic [TIME_W-1:0] time_of(int id);
    return (id <= NMAX) ? ent_time[id] : '0;
  endfunction

  function automatic logic [ID_W-1:0] play_match(int f);
    logic [ID_W-1:0] l, r;
    l = win_node[2*f];
    r = win_node[2*f+1];
    return (time_of(l) < time_of(r)) ? l : r;
  endfunction

  function automatic void replay_path(int id);
    int p, f;
    logic [ID_W-1:0] old;
    p = (id <= NMAX) ? int'(leaf_pos[id]) : 0;
    if (p >= NODES) p = 0;
    f = p / 2;
    while (f > 0 && win_node[f] == id) begin
      win_node[f] = play_match(f);
      f = f / 2;
    end
    while (f > 0) begin
      old = win_node[f];
      win_node[f] = play_match(f);
      if (win_node[f] == old) return;
      f = f / 2;
    end
  endfunction

  function automatic bit tree_insert(int id, logic [TIME_W-1:0] t);
    int c;
    logic [ID_W-1:0] moved;
    c = ent_count;
    if (c >= NMAX) return 1'b1;
    ent_time[id] = t;
    if (c == 0) begin
      win_node[1] = ID_W'(id);
      leaf_pos[id] = ID_W'(1);
      ent_count = 1;
      return 1'b0;
    end
    moved = win_node[c];
    win_node[2*c] = moved;
    win_node[2*c+1] = ID_W'(id);
    if (moved <= NMAX) leaf_pos[moved] = ID_W'(2*c);
    leaf_pos[id] = ID_W'(2*c + 1);
    ent_count = c + 1;
    replay_path(moved);
    return 1'b0;
  endfunction

  function automatic bit tree_delete(int id);
    int c, last, p;
    logic [ID_W-1:0] lo, hi;
    c = ent_count;
    if (c == 0) return 1'b1;
    if (c == 1) begin
      win_node[1] = '0;
      ent_count = 0;
      return 1'b0;
    end
    last = 2*c - 1;
    lo = win_node[last-1];
    hi = win_node[last];
    if (lo != id) begin
      if (lo <= NMAX) leaf_pos[lo] = ID_W'(last / 2);
      win_node[last/2] = lo;
      replay_path(lo);
      if (hi != id) begin
        p = (id <= NMAX) ? int'(leaf_pos[id]) : 0;
        if (p < NODES) win_node[p] = hi;
        if (hi <= NMAX) leaf_pos[hi] = ID_W'(p);
        replay_path(hi);
      end
    end else begin
      if (hi <= NMAX) leaf_pos[hi] = ID_W'(last / 2);
      win_node[last/2] = hi;
      replay_path(hi);
    end
    ent_count = c - 1;
    return 1'b0;
  endfunction

  function automatic res_t predict_winner(req_t r);
    res_t o;
    int id;
    bit err;
    logic [ID_W-1:0] w;
    id = r.entry_id;
    err = 1'b0;
    if (id >= 1 && id <= NMAX) begin
      case (r.operation)
        OP_INSERT: err = tree_insert(id, r.event_time);
        OP_DELETE: err = tree_delete(id);
        OP_UPDATE: begin
          ent_time[id] = r.event_time;
          replay_path(id);
        end
        default: ;
      endcase
    end
    w = (ent_count > 0) ? win_node[1] : '0;
    o.winner_id = w;
    o.winner_time = (ent_count > 0) ? time_of(w) : '0;
    o.entries = CNT_OUT_W'(ent_count);
    o.error = err;
    return o;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 9))
      0, 1: return TIME_W'($urandom_range(0, 7));
      2: return '1;
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic void mark_held(int id, bit on);
    int k;
    if (id < 1 || id > NMAX) return;
    if (on && !held[id]) begin
      held[id] = 1'b1;
      held_ids.push_back(id);
    end else if (!on && held[id]) begin
      held[id] = 1'b0;
      for (k = 0; k < held_ids.size(); k++)
        if (held_ids[k] == id) begin
          held_ids.delete(k);
          break;
        end
    end
  endfunction

  task automatic send_item(logic [1:0] op, int id, logic [TIME_W-1:0] t);
    req_t r;
    res_t o;
    int prev_count;
    r.operation = op_e'(op);
    r.entry_id = ID_W'(id);
    r.event_time = t;
    start_i <= 1'b1;
    in_i <= r;
    do @(posedge clk_i); while (busy_o);
    prev_count = ent_count;
    o = predict_winner(r);
    result_fifo.push_back(o);
    if (id >= 1 && id <= NMAX && !o.error) begin
      if (op == OP_INSERT) begin
        written[id] = 1'b1;
        mark_held(id, 1'b1);
      end else if (op == OP_DELETE && prev_count > 0) begin
        mark_held(id, 1'b0);
      end else if (op == OP_UPDATE) begin
        written[id] = 1'b1;
      end
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic int absent_id();
    int id;
    do id = $urandom_range(1, NMAX); while (held[id]);
    return id;
  endfunction

  function automatic int held_id();
    return held_ids[$urandom_range(0, held_ids.size() - 1)];
  endfunction

  task automatic test_directed();
    send_item(OP_DELETE, 5, '0);
    send_item(OP_INSERT, 1, '1);
    send_item(OP_DELETE, 1, '0);
    send_item(OP_INSERT, NMAX, '0);
    send_item(OP_INSERT, 2, '0);
    send_item(OP_INSERT, 3, 48'h5);
    send_item(OP_INSERT, 4, '1);
    send_item(OP_UPDATE, 2, 48'h5);
    send_item(OP_UPDATE, 4, 48'h1);
    send_item(OP_UPDATE, NMAX, 48'hAAAA_AAAA_AAAA);
    send_item(OP_INSERT, 0, 48'h1);
    send_item(OP_DELETE, 2047, '0);
    send_item(OP_UPDATE, 1025, 48'h5555_5555_5555);
    send_item(OP_UNUSED, 3, '0);
    send_item(OP_DELETE, 3, '0);
    send_item(OP_DELETE, NMAX, '0);
    send_item(OP_DELETE, 2, '0);
    send_item(OP_DELETE, 4, '0);
    send_item(OP_DELETE, 4, '0);
  endtask

  // Grow until full, push past full, drain to empty, then mix freely.
  task automatic test_random(int n_items);
    int i, phase, full_hits, pick;
    phase = 0;
    full_hits = 0;
    for (i = 0; i < n_items; i++) begin
      if (phase == 0 && ent_count == NMAX) begin
        if (++full_hits > 3) phase = 1;
      end
      if (phase == 1 && ent_count == 0) phase = 2;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(2'($urandom_range(0, 3)), $urandom_range(NMAX + 1, 2047), rand_time());
      end else if (pick < 6) begin
        send_item(OP_UNUSED, $urandom_range(0, 2047), rand_time());
      end else if (pick < 8) begin
        send_item(2'($urandom_range(0, 3)), 0, rand_time());
      end else if (ent_count == NMAX) begin
        if ($urandom_range(0, 1)) send_item(OP_INSERT, $urandom_range(1, NMAX), rand_time());
        else send_item(OP_UPDATE, held_id(), rand_time());
      end else if (ent_count == 0) begin
        if ($urandom_range(0, 3) == 0) send_item(OP_DELETE, $urandom_range(1, NMAX), '0);
        else send_item(OP_INSERT, absent_id(), rand_time());
      end else begin
        pick = $urandom_range(0, 99);
        if ((phase == 0 && pick < 85) || (phase == 1 && pick < 10) ||
            (phase == 2 && pick < 40))
          send_item(OP_INSERT, absent_id(), rand_time());
        else if ((phase == 0 && pick < 92) || (phase == 1 && pick < 85) ||
                 (phase == 2 && pick < 75))
          send_item(OP_DELETE, held_id(), rand_time());
        else
          send_item(OP_UPDATE, held_id(), rand_time());
      end
    end
  endtask

  // Presence violations leave the tree inconsistent, so they come last.
  task automatic test_presence_misuse();
    int id, gone;
    gone = 0;
    for (id = 1; id <= NMAX; id++)
      if (written[id] && !held[id]) gone = id;
    if (ent_count == 0) send_item(OP_INSERT, absent_id(), 48'h10);
    send_item(OP_INSERT, held_id(), 48'h3);
    if (gone != 0) begin
      send_item(OP_UPDATE, gone, 48'h2);
      send_item(OP_DELETE, gone, '0);
    end
  endtask

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && valid_o) begin
      if (result_fifo.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_o);
        errors++;
      end else begin
        exp_r = result_fifo.pop_front();
        if (res_o.winner_id !== exp_r.winner_id) begin
          $display("%0t: winner_id expected %0d actual %0d", $time,
                   exp_r.winner_id, res_o.winner_id);
          errors++;
        end
        if (res_o.winner_time !== exp_r.winner_time) begin
          $display("%0t: winner_time expected %h actual %h", $time,
                   exp_r.winner_time, res_o.winner_time);
          errors++;
        end
        if (res_o.entries !== exp_r.entries) begin
          $display("%0t: entries expected %0d actual %0d", $time,
                   exp_r.entries, res_o.entries);
          errors++;
        end
        if (res_o.error !== exp_r.error) begin
          $display("%0t: error expected %b actual %b", $time,
                   exp_r.error, res_o.error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int k;
    errors = 0;
    idle_cnt = 0;
    idle_en = 1'b1;
    ent_count = 0;
    for (k = 0; k < NODES; k++) win_node[k] = '0;
    for (k = 0; k <= NMAX; k++) begin
      leaf_pos[k] = '0;
      ent_time[k] = '0;
      held[k] = 1'b0;
      written[k] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(1550);
    idle_en = 1'b0;
    test_random(200);
    test_presence_misuse();
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/tteq_pkg.sv
src/tournament_tree_event_queue_top.sv
src/tteq_checker.sv
tb/sv/tb_tournament_tree_event_queue_top.sv
